// ===== rtl/core/crcr_pkg.sv =====
// Shared types and constants for the circle/rectangle collision response block.
// Request/result structs, square-root chain link and side-band payload.
// No dependencies.
package crcr_pkg;

	localparam int CoordW = 24;                 // Q15.8 coordinate width
	localparam int RadW   = 16;                 // Q8.8 radius width
	localparam int SizeW  = 23;                 // wall width/height
	localparam int EdgeW  = CoordW + 1;         // right/bottom edge, full width
	localparam int WideW  = CoordW + 2;         // headroom for edge compares
	localparam int DiffW  = CoordW;             // |dx|, |dy| magnitude
	localparam int SqW    = 2 * DiffW;          // one square
	localparam int SumW   = SqW + 1;            // dx^2 + dy^2
	localparam int NCells = (SumW + 1) / 2;     // one root bit per cell
	localparam int RadicW = 2 * NCells;
	localparam int RootW  = NCells;
	localparam int RemW   = NCells + 1;
	localparam int ShiftW = RadW + 1;           // dist - radius, signed

	localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
	localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};

	typedef struct packed {
		logic signed [CoordW-1:0] ball_x;
		logic signed [CoordW-1:0] ball_y;
		logic        [RadW-1:0]   ball_radius;
		logic signed [CoordW-1:0] ball_vx;
		logic signed [CoordW-1:0] ball_vy;
		logic signed [CoordW-1:0] wall_x;
		logic signed [CoordW-1:0] wall_y;
		logic        [SizeW-1:0]  wall_w;
		logic        [SizeW-1:0]  wall_h;
	} req_t;

	typedef struct packed {
		logic                     hit;
		logic                     flipped_axis;
		logic signed [CoordW-1:0] new_x;
		logic signed [CoordW-1:0] new_y;
		logic signed [CoordW-1:0] new_vx;
		logic signed [CoordW-1:0] new_vy;
	} res_t;

	// Ball data and edge decisions that ride alongside the root computation.
	typedef struct packed {
		logic signed [CoordW-1:0] ball_x;
		logic signed [CoordW-1:0] ball_y;
		logic        [RadW-1:0]   ball_radius;
		logic signed [CoordW-1:0] ball_vx;
		logic signed [CoordW-1:0] ball_vy;
		logic                     in_span;
		logic                     near_x;
		logic                     near_y;
	} side_t;

	typedef struct packed {
		logic [RadicW-1:0] radicand;
		logic [RootW-1:0]  root;
		logic [RemW-1:0]   rem;
	} sqrt_t;

endpackage

// ===== rtl/core/crcr_prep.sv =====
// Front end: edge computation, clamp to rectangle, squares and their sum.
// Four pipeline stages feeding the square-root cell chain.
// Depends on crcr_pkg.
module crcr_prep (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  crcr_pkg::req_t   req,
	output logic             out_valid,
	output crcr_pkg::sqrt_t  out_sq,
	output crcr_pkg::side_t  out_side
);

	logic                                   valid_s1, valid_s2, valid_s3;
	crcr_pkg::req_t                         req_s1;
	logic signed [crcr_pkg::EdgeW-1:0]      right_s1, bottom_s1;
	logic        [crcr_pkg::DiffW-1:0]      adx_s2, ady_s2;
	crcr_pkg::side_t                        side_s2, side_s3;
	logic        [crcr_pkg::SqW-1:0]        sqx_s3, sqy_s3;

	logic signed [crcr_pkg::WideW-1:0] cx, cy, rx, ry, rgt, bot, rad;
	logic                              lt_x, gt_x, lt_y, gt_y;
	logic signed [crcr_pkg::WideW-1:0] d_lo_x, d_hi_x, d_lo_y, d_hi_y;
	logic        [crcr_pkg::DiffW-1:0] adx, ady;
	crcr_pkg::side_t                   side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			out_valid <= valid_s3;
		end
	end

	// Stage 1: latch request, form far edges without wrap.
	always_ff @(posedge clk) begin
		req_s1    <= req;
		right_s1  <= crcr_pkg::EdgeW'(req.wall_x) + crcr_pkg::EdgeW'({2'b00, req.wall_w});
		bottom_s1 <= crcr_pkg::EdgeW'(req.wall_y) + crcr_pkg::EdgeW'({2'b00, req.wall_h});
	end

	// Stage 2: clamp, distance magnitudes, response axis and edge side.
	always_comb begin
		cx  = crcr_pkg::WideW'(req_s1.ball_x);
		cy  = crcr_pkg::WideW'(req_s1.ball_y);
		rx  = crcr_pkg::WideW'(req_s1.wall_x);
		ry  = crcr_pkg::WideW'(req_s1.wall_y);
		rgt = crcr_pkg::WideW'(right_s1);
		bot = crcr_pkg::WideW'(bottom_s1);
		rad = $signed({{(crcr_pkg::WideW-crcr_pkg::RadW){1'b0}}, req_s1.ball_radius});

		lt_x   = cx < rx;
		gt_x   = cx > rgt;
		lt_y   = cy < ry;
		gt_y   = cy > bot;
		d_lo_x = rx - cx;
		d_hi_x = cx - rgt;
		d_lo_y = ry - cy;
		d_hi_y = cy - bot;

		adx = lt_x ? d_lo_x[crcr_pkg::DiffW-1:0] :
		      gt_x ? d_hi_x[crcr_pkg::DiffW-1:0] : '0;
		ady = lt_y ? d_lo_y[crcr_pkg::DiffW-1:0] :
		      gt_y ? d_hi_y[crcr_pkg::DiffW-1:0] : '0;

		side.ball_x      = req_s1.ball_x;
		side.ball_y      = req_s1.ball_y;
		side.ball_radius = req_s1.ball_radius;
		side.ball_vx     = req_s1.ball_vx;
		side.ball_vy     = req_s1.ball_vy;
		side.in_span     = ((cx - rad) > rx) && ((cx + rad) < rgt);
		// A zero-size wall clamps to its near edge from either side.
		side.near_x      = (cx <= rx) || (req_s1.wall_w == '0);
		side.near_y      = (cy <= ry) || (req_s1.wall_h == '0);
	end

	always_ff @(posedge clk) begin
		adx_s2  <= adx;
		ady_s2  <= ady;
		side_s2 <= side;
	end

	// Stage 3: squares.
	always_ff @(posedge clk) begin
		sqx_s3  <= crcr_pkg::SqW'(adx_s2) * crcr_pkg::SqW'(adx_s2);
		sqy_s3  <= crcr_pkg::SqW'(ady_s2) * crcr_pkg::SqW'(ady_s2);
		side_s3 <= side_s2;
	end

	// Stage 4: sum of squares becomes the radicand of the root chain.
	always_ff @(posedge clk) begin
		out_sq.radicand <= crcr_pkg::RadicW'(crcr_pkg::SumW'(sqx_s3) + crcr_pkg::SumW'(sqy_s3));
		out_sq.root     <= '0;
		out_sq.rem      <= '0;
		out_side        <= side_s3;
	end

endmodule

// ===== rtl/core/crcr_sqrt_cell.sv =====
// One cell of the square-root chain: resolves one root bit per cycle.
// Restoring digit-by-digit step; passes side-band payload along.
// Depends on crcr_pkg.
module crcr_sqrt_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  crcr_pkg::sqrt_t  in_sq,
	input  crcr_pkg::side_t  in_side,
	output logic             out_valid,
	output crcr_pkg::sqrt_t  out_sq,
	output crcr_pkg::side_t  out_side
);

	logic [crcr_pkg::RemW+1:0] cur, trial, diff;
	logic                      ge;

	always_comb begin
		cur   = {in_sq.rem, in_sq.radicand[crcr_pkg::RadicW-1 -: 2]};
		trial = {1'b0, in_sq.root, 2'b01};
		ge    = cur >= trial;
		diff  = cur - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_sq.radicand <= {in_sq.radicand[crcr_pkg::RadicW-3:0], 2'b00};
		out_sq.root     <= {in_sq.root[crcr_pkg::RootW-2:0], ge};
		out_sq.rem      <= ge ? diff[crcr_pkg::RemW-1:0] : cur[crcr_pkg::RemW-1:0];
		out_side        <= in_side;
	end

endmodule

// ===== rtl/core/crcr_resp.sv =====
// Back end: hit test against the radius, then position and velocity response.
// Two pipeline stages, saturating to the 24 bit signed range.
// Depends on crcr_pkg.
module crcr_resp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [crcr_pkg::RootW-1:0]    distance,
	input  crcr_pkg::side_t               in_side,
	output logic                          done,
	output crcr_pkg::res_t                res
);

	logic                               valid_s1, hit_s1;
	logic signed [crcr_pkg::ShiftW-1:0] shift_s1;
	crcr_pkg::side_t                    side_s1;

	logic signed [crcr_pkg::WideW-1:0]  pos, moved;
	logic signed [crcr_pkg::CoordW-1:0] pos_sat, vx_neg, vy_neg;
	logic                               near, flip_x, flip_y;
	crcr_pkg::res_t                     res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			done     <= valid_s1;
		end
	end

	// Stage 1: compare distance to radius; shift is exact whenever it is used.
	always_ff @(posedge clk) begin
		hit_s1   <= distance <= crcr_pkg::RootW'(in_side.ball_radius);
		shift_s1 <= $signed(distance[crcr_pkg::ShiftW-1:0]) -
		            $signed({1'b0, in_side.ball_radius});
		side_s1  <= in_side;
	end

	// Stage 2: move along the response axis, negate its velocity.
	always_comb begin
		flip_y = hit_s1 && side_s1.in_span;
		flip_x = hit_s1 && !side_s1.in_span;
		pos    = side_s1.in_span ? crcr_pkg::WideW'(side_s1.ball_y) :
		                           crcr_pkg::WideW'(side_s1.ball_x);
		near   = side_s1.in_span ? side_s1.near_y : side_s1.near_x;
		moved  = near ? pos + crcr_pkg::WideW'(shift_s1) : pos - crcr_pkg::WideW'(shift_s1);

		if (moved > crcr_pkg::WideW'(crcr_pkg::CoordMax)) begin
			pos_sat = crcr_pkg::CoordMax;
		end else if (moved < crcr_pkg::WideW'(crcr_pkg::CoordMin)) begin
			pos_sat = crcr_pkg::CoordMin;
		end else begin
			pos_sat = moved[crcr_pkg::CoordW-1:0];
		end

		vx_neg = (side_s1.ball_vx == crcr_pkg::CoordMin) ? crcr_pkg::CoordMax : -side_s1.ball_vx;
		vy_neg = (side_s1.ball_vy == crcr_pkg::CoordMin) ? crcr_pkg::CoordMax : -side_s1.ball_vy;

		res_d.hit          = hit_s1;
		res_d.flipped_axis = flip_x;
		res_d.new_x        = flip_x ? pos_sat : side_s1.ball_x;
		res_d.new_y        = flip_y ? pos_sat : side_s1.ball_y;
		res_d.new_vx       = flip_x ? vx_neg  : side_s1.ball_vx;
		res_d.new_vy       = flip_y ? vy_neg  : side_s1.ball_vy;
	end

	always_ff @(posedge clk) begin
		res <= res_d;
	end

	a_no_flip_without_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done && !res.hit |-> !res.flipped_axis)
		else $error("flipped_axis set without a hit");

	a_done_follows_stage: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("result strobe lost after hit stage");

	a_hit_carried: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && hit_s1 |=> done && res.hit)
		else $error("hit decision not carried to result");

endmodule

// ===== rtl/core/circle_rect_collision_response.sv =====
// Top level of the ball versus axis-aligned wall collision response block.
// Instantiates crcr_prep, the crcr_sqrt_cell chain and crcr_resp; uses crcr_pkg.
//
// A request is taken on every clock edge with start high; busy is never raised, so one
// ball/wall pair enters per cycle. Each result appears on res for one cycle with done
// high, after passing four front-end stages (edges, clamp, squares, sum), a chain of 25
// square-root cells that each resolve one root bit, and two response stages.
// Results leave in request order and cannot be held off by the receiver.
module circle_rect_collision_response (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  crcr_pkg::req_t  req,
	output logic            done,
	output crcr_pkg::res_t  res
);

	logic            link_valid [0:crcr_pkg::NCells];
	crcr_pkg::sqrt_t link_sq    [0:crcr_pkg::NCells];
	crcr_pkg::side_t link_side  [0:crcr_pkg::NCells];

	assign busy = 1'b0;

	crcr_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.req       (req),
		.out_valid (link_valid[0]),
		.out_sq    (link_sq[0]),
		.out_side  (link_side[0])
	);

	for (genvar i = 0; i < crcr_pkg::NCells; i++) begin : g_cell
		crcr_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (link_valid[i]),
			.in_sq     (link_sq[i]),
			.in_side   (link_side[i]),
			.out_valid (link_valid[i+1]),
			.out_sq    (link_sq[i+1]),
			.out_side  (link_side[i+1])
		);
	end

	crcr_resp u_resp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (link_valid[crcr_pkg::NCells]),
		.distance (link_sq[crcr_pkg::NCells].root),
		.in_side  (link_side[crcr_pkg::NCells]),
		.done     (done),
		.res      (res)
	);

endmodule
